// ===== hw/rtl/ple_pkg.sv =====
// Package for the positional list engine: list size, derived widths,
// operation and status codes, and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	// list size and derived widths
	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int TOT_W    = 7;
	localparam int COORD_W  = 32;
	localparam int ENTRY_W  = 2 * COORD_W;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT,
		S_PUT,
		S_FINISH
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch request fields
		logic setup;   // load shift pointer and move count
		logic rd_pos;  // read the entry at the request position
		logic step;    // one move: read source, write it one place over next cycle
		logic put;     // write the new pair at the request position
		logic commit;  // update count, load result register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_kind_t kind;
		logic     ok;
		logic     rem_zero;
	} dp_stat_t;

endpackage

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: ordered list of coordinate pairs
// with insert, delete, read and clear. Instantiates ple_ctrl and ple_dp; uses ple_pkg.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  kind, position, in_x, in_y
//   out       out_valid / out_stall status, out_x, out_y, entry_total
//
// Read, clear and rejected requests go from accept through check to finish.
// Insert and delete also shift M entries, M = count - position for insert and
// count - position - 1 for delete; insert then puts the new pair. The single memory
// write port moves one entry per cycle. Reset clears the count and the control;
// memory is not cleared.
// A waiting result does not block the next request; it holds it only at hand-off.
`timescale 1ns / 1ps

module positional_list_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            kind,
	input  logic [ple_pkg::POS_W-1:0]             position,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_x,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic signed [ple_pkg::COORD_W-1:0]    out_x,
	output logic signed [ple_pkg::COORD_W-1:0]    out_y,
	output logic [ple_pkg::TOT_W-1:0]             entry_total
);

	ple_pkg::dp_cmd_t  cmd;
	ple_pkg::dp_stat_t stat;

	// sequencing
	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// storage and checks
	ple_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.kind        (kind),
		.position    (position),
		.in_x        (in_x),
		.in_y        (in_y),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.out_x       (out_x),
		.out_y       (out_y),
		.entry_total (entry_total)
	);

endmodule

// ===== hw/rtl/ple_dp.sv =====
// Datapath of the positional list engine: entry memory, entry count,
// shift pointer and move counter, range checks and result register.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [1:0]                            kind,
	input  logic [ple_pkg::POS_W-1:0]             position,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_x,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_y,
	input  ple_pkg::dp_cmd_t                      cmd,
	output ple_pkg::dp_stat_t                     stat,
	output logic [1:0]                            status,
	output logic signed [ple_pkg::COORD_W-1:0]    out_x,
	output logic signed [ple_pkg::COORD_W-1:0]    out_y,
	output logic [ple_pkg::TOT_W-1:0]             entry_total
);

	// entry memory, no reset
	logic [ple_pkg::ENTRY_W-1:0] mem [ple_pkg::CAPACITY];

	// latched request
	ple_pkg::op_kind_t            kind_q;
	logic [ple_pkg::POS_W-1:0]    pos_q;
	logic [ple_pkg::COORD_W-1:0]  x_q;
	logic [ple_pkg::COORD_W-1:0]  y_q;

	// list state and shift control
	logic [ple_pkg::CNT_W-1:0]    cnt_q;
	logic [ple_pkg::IDX_W-1:0]    src_q;
	logic [ple_pkg::CNT_W-1:0]    rem_q;
	logic                         mv_pend_s1;
	logic [ple_pkg::IDX_W-1:0]    mv_dst_s1;
	logic [ple_pkg::ENTRY_W-1:0]  rdata_s1;

	// result register
	ple_pkg::status_t             status_q;
	logic [ple_pkg::COORD_W-1:0]  out_x_q;
	logic [ple_pkg::COORD_W-1:0]  out_y_q;
	logic [ple_pkg::TOT_W-1:0]    total_q;

	logic [ple_pkg::CMP_W-1:0]    pos_c;
	logic [ple_pkg::CMP_W-1:0]    cnt_c;
	logic [ple_pkg::CMP_W-1:0]    cnt_new_c;
	logic [ple_pkg::CMP_W-1:0]    rem_c;
	logic [ple_pkg::CMP_W-1:0]    src_c;
	ple_pkg::status_t             status_d;
	logic                         ok;
	logic                         is_ins;
	logic [ple_pkg::IDX_W-1:0]    pos_addr;
	logic [ple_pkg::IDX_W-1:0]    src_nxt;
	logic [ple_pkg::IDX_W-1:0]    step_dst;
	logic                         rd_en;
	logic [ple_pkg::IDX_W-1:0]    rd_addr;
	logic                         we;
	logic [ple_pkg::IDX_W-1:0]    waddr;
	logic [ple_pkg::ENTRY_W-1:0]  wdata;

	// range checks on the latched request
	always_comb begin
		pos_c    = ple_pkg::CMP_W'(pos_q);
		cnt_c    = ple_pkg::CMP_W'(cnt_q);
		pos_addr = pos_c[ple_pkg::IDX_W-1:0];
		is_ins   = (kind_q == ple_pkg::OP_INSERT);
		unique case (kind_q)
			ple_pkg::OP_INSERT: begin
				if (cnt_c == ple_pkg::CMP_W'(ple_pkg::CAPACITY))
					status_d = ple_pkg::ST_FULL;
				else if (pos_c > cnt_c)
					status_d = ple_pkg::ST_RANGE;
				else
					status_d = ple_pkg::ST_OK;
			end
			ple_pkg::OP_DELETE, ple_pkg::OP_READ: begin
				status_d = (pos_c >= cnt_c) ? ple_pkg::ST_RANGE : ple_pkg::ST_OK;
			end
			default: begin
				status_d = ple_pkg::ST_OK;
			end
		endcase
		ok = (status_d == ple_pkg::ST_OK);
	end

	// count after the operation
	always_comb begin
		cnt_new_c = cnt_c;
		unique case (kind_q)
			ple_pkg::OP_INSERT: if (ok) cnt_new_c = cnt_c + ple_pkg::CMP_W'(1);
			ple_pkg::OP_DELETE: if (ok) cnt_new_c = cnt_c - ple_pkg::CMP_W'(1);
			ple_pkg::OP_READ:   cnt_new_c = cnt_c;
			default:            cnt_new_c = '0;
		endcase
	end

	// move count and first source: insert walks down from the top, delete walks up
	always_comb begin
		if (is_ins) begin
			rem_c = cnt_c - pos_c;
			src_c = cnt_c - ple_pkg::CMP_W'(1);
		end else begin
			rem_c = cnt_c - pos_c - ple_pkg::CMP_W'(1);
			src_c = pos_c + ple_pkg::CMP_W'(1);
		end
		src_nxt  = is_ins ? src_q - ple_pkg::IDX_W'(1) : src_q + ple_pkg::IDX_W'(1);
		step_dst = is_ins ? src_q + ple_pkg::IDX_W'(1) : src_q - ple_pkg::IDX_W'(1);
	end

	// memory port control: pending move write has the port, else the new pair
	always_comb begin
		rd_en   = cmd.rd_pos | cmd.step;
		rd_addr = cmd.rd_pos ? pos_addr : src_q;
		we      = mv_pend_s1 | cmd.put;
		waddr   = mv_pend_s1 ? mv_dst_s1 : pos_addr;
		wdata   = mv_pend_s1 ? rdata_s1 : {x_q, y_q};
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	// request latch, pointers, result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= ple_pkg::op_kind_t'(kind);
			pos_q  <= position;
			x_q    <= in_x;
			y_q    <= in_y;
		end
		if (cmd.setup) begin
			src_q <= src_c[ple_pkg::IDX_W-1:0];
			rem_q <= rem_c[ple_pkg::CNT_W-1:0];
		end else if (cmd.step) begin
			src_q <= src_nxt;
			rem_q <= rem_q - ple_pkg::CNT_W'(1);
		end
		mv_dst_s1 <= step_dst;
		if (cmd.commit) begin
			status_q <= status_d;
			total_q  <= cnt_new_c[ple_pkg::TOT_W-1:0];
			if (ok && kind_q == ple_pkg::OP_READ) begin
				out_x_q <= rdata_s1[ple_pkg::ENTRY_W-1:ple_pkg::COORD_W];
				out_y_q <= rdata_s1[ple_pkg::COORD_W-1:0];
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
			end
		end
	end

	// list count and move pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			mv_pend_s1 <= 1'b0;
		end else begin
			mv_pend_s1 <= cmd.step;
			if (cmd.commit)
				cnt_q <= cnt_new_c[ple_pkg::CNT_W-1:0];
		end
	end

	assign stat.kind     = kind_q;
	assign stat.ok       = ok;
	assign stat.rem_zero = (rem_q == '0);

	assign status      = status_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign entry_total = total_q;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// Controller of the positional list engine: sequences check, shift,
// put and result hand-off, and owns both channel handshakes.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output ple_pkg::dp_cmd_t   cmd,
	input  ple_pkg::dp_stat_t  stat
);

	ple_pkg::ctrl_state_t state_q;
	ple_pkg::ctrl_state_t state_d;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 is_shift_op;

	assign out_free    = ~out_valid_q | ~out_stall;
	assign is_shift_op = (stat.kind == ple_pkg::OP_INSERT) ||
	                     (stat.kind == ple_pkg::OP_DELETE);

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ple_pkg::S_CHECK;
				end
			end
			ple_pkg::S_CHECK: begin
				cmd.setup  = 1'b1;
				cmd.rd_pos = 1'b1;
				state_d    = (stat.ok && is_shift_op) ? ple_pkg::S_SHIFT : ple_pkg::S_FINISH;
			end
			ple_pkg::S_SHIFT: begin
				// last move's write lands in the cycle that sees rem_zero
				if (stat.rem_zero)
					state_d = (stat.kind == ple_pkg::OP_INSERT) ? ple_pkg::S_PUT
					                                             : ple_pkg::S_FINISH;
				else
					cmd.step = 1'b1;
			end
			ple_pkg::S_PUT: begin
				cmd.put = 1'b1;
				state_d = ple_pkg::S_FINISH;
			end
			ple_pkg::S_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ple_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.commit | (out_valid_q & out_stall);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== test/ple_checker.sv =====
// Checker for the positional list engine: watches both channels, keeps its own
// copy of the list, predicts each result and compares it field by field.
// Depends on ple_pkg for the list size, widths and codes.
`timescale 1ns / 1ps

module ple_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [1:0]                            kind,
	input  logic [ple_pkg::POS_W-1:0]             position,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_x,
	input  logic signed [ple_pkg::COORD_W-1:0]    in_y,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic [1:0]                            status,
	input  logic signed [ple_pkg::COORD_W-1:0]    out_x,
	input  logic signed [ple_pkg::COORD_W-1:0]    out_y,
	input  logic [ple_pkg::TOT_W-1:0]             entry_total,
	output int                                    mismatch_count,
	output int                                    pending
);

	import ple_pkg::*;

	typedef struct {
		status_t               st;
		logic [COORD_W-1:0]    x;
		logic [COORD_W-1:0]    y;
		logic [TOT_W-1:0]      total;
	} list_result_t;

	// shadow list contents and length
	logic [COORD_W-1:0] entry_x [CAPACITY];
	logic [COORD_W-1:0] entry_y [CAPACITY];
	int unsigned        n_entries;

	list_result_t awaited_results [$];
	int unsigned  results_seen;

	initial begin
		mismatch_count = 0;
		pending        = 0;
		n_entries      = 0;
		results_seen   = 0;
	end

	// apply one request to the shadow list and return the result it should give
	function automatic list_result_t apply_list_op(op_kind_t op, int unsigned pos,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		list_result_t r;
		r.st = ST_OK;
		r.x  = '0;
		r.y  = '0;
		case (op)
			OP_INSERT: begin
				// full is checked before position
				if (n_entries >= CAPACITY)
					r.st = ST_FULL;
				else if (pos > n_entries)
					r.st = ST_RANGE;
				else begin
					for (int i = n_entries; i > pos; i--) begin
						entry_x[i] = entry_x[i-1];
						entry_y[i] = entry_y[i-1];
					end
					entry_x[pos] = x;
					entry_y[pos] = y;
					n_entries++;
				end
			end
			OP_DELETE: begin
				if (pos >= n_entries)
					r.st = ST_RANGE;
				else begin
					for (int i = pos; i + 1 < n_entries; i++) begin
						entry_x[i] = entry_x[i+1];
						entry_y[i] = entry_y[i+1];
					end
					n_entries--;
				end
			end
			OP_READ: begin
				if (pos >= n_entries)
					r.st = ST_RANGE;
				else begin
					r.x = entry_x[pos];
					r.y = entry_y[pos];
				end
			end
			default: begin
				n_entries = 0;
			end
		endcase
		r.total = TOT_W'(n_entries);
		return r;
	endfunction

	task automatic note_mismatch(string field, logic [COORD_W-1:0] want,
			logic [COORD_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: result %0d %s mismatch: expected %h, got %h",
				$time, results_seen, field, want, got);
	endtask

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			n_entries = 0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_list_op(op_kind_t'(kind), position, in_x, in_y));
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with no request waiting: status %0d total %0d",
							$time, status, entry_total);
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.st)
						note_mismatch("status", COORD_W'(want.st), COORD_W'(status));
					if (out_x !== want.x)
						note_mismatch("out_x", want.x, out_x);
					if (out_y !== want.y)
						note_mismatch("out_y", want.y, out_y);
					if (entry_total !== want.total)
						note_mismatch("entry_total", COORD_W'(want.total), COORD_W'(entry_total));
				end
				results_seen++;
			end
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the positional list engine: clock, reset, request stimulus,
// random stalls on the result side, watchdog and verdict.
// Depends on ple_pkg, positional_list_engine and ple_checker.
`timescale 1ns / 1ps

module tb_top;

	import ple_pkg::*;

	localparam int REQUEST_TARGET = 450;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int CALM_TAIL      = 60;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic [1:0]                kind        = OP_READ;
	logic [POS_W-1:0]          position    = '0;
	logic signed [COORD_W-1:0] in_x        = '0;
	logic signed [COORD_W-1:0] in_y        = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic [1:0]                status;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic [TOT_W-1:0]          entry_total;

	int mismatch_count;
	int pending;

	// stimulus-side view of the list length, used to aim positions and to know when the list is full
	int unsigned list_len  = 0;
	int unsigned sent      = 0;
	bit          idle_on   = 1'b0;

	always #5 clk = ~clk;

	positional_list_engine uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.position    (position),
		.in_x        (in_x),
		.in_y        (in_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_x       (out_x),
		.out_y       (out_y),
		.entry_total (entry_total)
	);

	ple_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.position       (position),
		.in_x           (in_x),
		.in_y           (in_y),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.out_x          (out_x),
		.out_y          (out_y),
		.entry_total    (entry_total),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	// present one request, hold it until accepted
	task automatic send_request(op_kind_t op, int unsigned pos,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		position <= POS_W'(pos);
		in_x     <= x;
		in_y     <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		case (op)
			OP_INSERT: if (list_len < CAPACITY && pos <= list_len) list_len++;
			OP_DELETE: if (pos < list_len) list_len--;
			OP_CLEAR:  list_len = 0;
			default: ;
		endcase
		sent++;
	endtask

	// hold off new requests until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// mostly well-aimed operations, with some positions anywhere in the field
	task automatic random_request();
		int unsigned roll;
		int unsigned pos;
		op_kind_t    op;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			op = OP_INSERT;
		else if (roll < 70)
			op = OP_DELETE;
		else if (roll < 97)
			op = OP_READ;
		else
			op = OP_CLEAR;
		if ($urandom_range(0, 9) == 0)
			pos = $urandom_range(0, 127);
		else if (op == OP_INSERT)
			pos = $urandom_range(0, list_len);
		else
			pos = (list_len == 0) ? 0 : $urandom_range(0, list_len - 1);
		send_request(op, pos, pick_coord(), pick_coord());
	endtask

	// fill the list to capacity, then poke at the full list
	task automatic fill_list();
		while (list_len < CAPACITY)
			send_request(OP_INSERT, $urandom_range(0, list_len), pick_coord(), pick_coord());
		send_request(OP_INSERT, 0, $urandom, $urandom);
		send_request(OP_INSERT, CAPACITY, $urandom, $urandom);
		send_request(OP_INSERT, 127, $urandom, $urandom);
		send_request(OP_READ, CAPACITY - 1, $urandom, $urandom);
		send_request(OP_READ, CAPACITY, $urandom, $urandom);
		send_request(OP_DELETE, CAPACITY - 1, $urandom, $urandom);
		send_request(OP_INSERT, CAPACITY - 1, $urandom, $urandom);
		send_request(OP_DELETE, 0, $urandom, $urandom);
	endtask

	// result-side stalls in random bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long with nothing accepted on either side
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: watchdog expired", $time);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int fills;
		fills = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// directed: empty list, extremes, shifts, ends of the list, clear
		send_request(OP_READ, 0, '0, '0);
		send_request(OP_DELETE, 0, '0, '0);
		send_request(OP_INSERT, 1, 32'h1234_5678, 32'h9abc_def0);
		send_request(OP_INSERT, 0, 32'h8000_0000, 32'h7fff_ffff);
		send_request(OP_INSERT, 1, 32'h7fff_ffff, 32'h8000_0000);
		send_request(OP_INSERT, 0, 32'hffff_ffff, 32'h0000_0000);
		send_request(OP_INSERT, 2, 32'h5555_5555, 32'haaaa_aaaa);
		for (int i = 0; i < 4; i++)
			send_request(OP_READ, i, $urandom, $urandom);
		send_request(OP_READ, 4, '0, '0);
		send_request(OP_INSERT, 6, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
		send_request(OP_DELETE, 1, '0, '0);
		send_request(OP_DELETE, 2, 32'hffff_ffff, 32'hffff_ffff);
		send_request(OP_READ, 1, '0, '0);
		send_request(OP_INSERT, 127, 32'haaaa_aaaa, 32'h5555_5555);
		send_request(OP_DELETE, 127, '0, '0);
		send_request(OP_READ, 64, '0, '0);
		send_request(OP_DELETE, 0, $urandom, $urandom);
		send_request(OP_CLEAR, 127, 32'hffff_ffff, 32'hffff_ffff);
		send_request(OP_READ, 0, '0, '0);
		send_request(OP_CLEAR, 0, '0, '0);
		wait_drained();

		// random part, with full-list episodes, drain pauses and quiet stretches
		while (sent < REQUEST_TARGET) begin
			idle_on = ((sent % 100) < 70) && (sent + CALM_TAIL < REQUEST_TARGET);
			if ((fills == 0 && sent >= 120) || (fills == 1 && sent >= 300)) begin
				fill_list();
				fills++;
			end
			if (sent >= 220 && sent < 222)
				wait_drained();
			random_request();
		end
		in_valid <= 1'b0;
		idle_on = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/ple_pkg.sv
hw/rtl/ple_dp.sv
hw/rtl/ple_ctrl.sv
hw/rtl/positional_list_engine.sv
test/ple_checker.sv
test/tb_top.sv
